// ===== design/ptdt_pkg.sv =====
// Package for the periodic task dispatch table: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
`default_nettype none

package ptdt_pkg;

  localparam int MaxTasks = 8;
  localparam int SlotW    = 3;
  localparam int CntW     = 4;
  localparam int KeyW     = 8;
  localparam int PerW     = 32;
  localparam int RemCntW  = 5;

  // Input opcodes
  typedef enum logic [2:0] {
    OpTick    = 3'd0,
    OpAdd     = 3'd1,
    OpSuspend = 3'd2,
    OpResume  = 3'd3,
    OpQuery   = 3'd4,
    OpProcess = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KindDispatch = 2'd0,
    KindState    = 2'd1,
    KindAdd      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TaskRunning   = 2'd0,
    TaskSuspended = 2'd1,
    TaskMissing   = 2'd2
  } task_state_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StTickEntry,
    StTickWait,
    StProcScan
  } fsm_e;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [KeyW-1:0] task_key;
    logic [PerW-1:0] interval;
  } in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [KeyW-1:0]  task_key_out;
    logic [SlotW-1:0] slot_out;
    logic [1:0]       task_state;
    logic             dispatched;
    logic             add_ok;
    logic             last;
  } out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic cnt_inc;
    logic rem_start;
    logic tick_finish;
    logic exec;
    logic proc_step;
    logic proc_end;
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_end;
    logic tick_eligible;
    logic rem_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/ptdt_rem.sv =====
// Serial 32-bit remainder unit, one quotient bit per cycle; reports whether
// the remainder is zero. Depends on ptdt_pkg.
`default_nettype none

module ptdt_rem (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [ptdt_pkg::PerW-1:0] dividend_i,
  input  wire logic [ptdt_pkg::PerW-1:0] divisor_i,
  output logic                          done_o,
  output logic                          zero_o
);

  logic [ptdt_pkg::PerW-1:0]    rem_q, rem_d, dvd_q, dvd_d, div_q, div_d;
  logic [ptdt_pkg::RemCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d, done_q, done_d;
  logic [ptdt_pkg::PerW:0]      trial;

  // One restoring step per cycle
  always_comb begin
    trial  = {rem_q, dvd_q[ptdt_pkg::PerW-1]};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = ptdt_pkg::PerW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[ptdt_pkg::PerW-1:0];
      end
      dvd_d = {dvd_q[ptdt_pkg::PerW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

`default_nettype wire

// ===== design/ptdt_datapath.sv =====
// Datapath of the dispatch table: task entries, scan index, key match and
// the result register. Depends on ptdt_pkg and ptdt_rem.
`default_nettype none

module ptdt_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ptdt_pkg::in_t   cmd_i,
  input  wire ptdt_pkg::ctrl_t ctrl_i,
  output ptdt_pkg::stat_t      stat_o,
  output ptdt_pkg::out_t       result_o,
  output logic                 result_valid_o
);

  localparam int N = ptdt_pkg::MaxTasks;

  ptdt_pkg::in_t                 cmd_q;
  logic [ptdt_pkg::KeyW-1:0]     key_q  [N];
  logic [ptdt_pkg::PerW-1:0]     per_q  [N];
  logic [ptdt_pkg::PerW-1:0]     ctr_q  [N];
  logic [N-1:0]                  pend_q, susp_q;
  logic [ptdt_pkg::CntW-1:0]     count_q, idx_q;
  logic                          sent_q;
  ptdt_pkg::out_t                res_q, res_d;
  logic                          res_valid_q, res_valid_d;

  logic [ptdt_pkg::SlotW-1:0]    idx, hit_slot, new_slot;
  logic                          hit, later, rem_done, rem_zero;
  logic [N-1:0]                  disp_vec;
  logic [ptdt_pkg::PerW-1:0]     ctr_next;

  assign idx      = idx_q[ptdt_pkg::SlotW-1:0];
  assign new_slot = count_q[ptdt_pkg::SlotW-1:0];
  assign ctr_next = ctr_q[idx] + 1'b1;

  // Key match, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int e = N - 1; e >= 0; e--) begin
      if (ptdt_pkg::CntW'(e) < count_q && key_q[e] == cmd_q.task_key) begin
        hit      = 1'b1;
        hit_slot = ptdt_pkg::SlotW'(e);
      end
    end
  end

  // Tasks that will dispatch, and whether one follows the current index
  always_comb begin
    later = 1'b0;
    for (int e = 0; e < N; e++) begin
      disp_vec[e] = (ptdt_pkg::CntW'(e) < count_q) && pend_q[e] && !susp_q[e];
      if (disp_vec[e] && ptdt_pkg::CntW'(e) > idx_q) begin
        later = 1'b1;
      end
    end
  end

  ptdt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.rem_start),
    .dividend_i (ctr_next),
    .divisor_i  (per_q[idx]),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  assign stat_o.idx_end       = (idx_q == count_q);
  assign stat_o.tick_eligible = (per_q[idx] != '0) && !susp_q[idx];
  assign stat_o.rem_done      = rem_done;

  // Result payload and strobe
  always_comb begin
    res_d       = res_q;
    res_valid_d = 1'b0;
    if (ctrl_i.exec) begin
      case (cmd_q.opcode)
        ptdt_pkg::OpAdd: begin
          res_d              = '0;
          res_d.result_kind  = ptdt_pkg::KindAdd;
          res_d.task_key_out = cmd_q.task_key;
          res_d.last         = 1'b1;
          res_valid_d        = 1'b1;
          if (hit) begin
            res_d.slot_out = hit_slot;
            res_d.add_ok   = 1'b1;
          end else if (count_q < ptdt_pkg::CntW'(N)) begin
            res_d.slot_out = new_slot;
            res_d.add_ok   = 1'b1;
          end
        end
        ptdt_pkg::OpQuery: begin
          res_d              = '0;
          res_d.result_kind  = ptdt_pkg::KindState;
          res_d.task_key_out = cmd_q.task_key;
          res_d.last         = 1'b1;
          res_valid_d        = 1'b1;
          if (hit) begin
            res_d.slot_out   = hit_slot;
            res_d.task_state = susp_q[hit_slot] ? ptdt_pkg::TaskSuspended
                                                : ptdt_pkg::TaskRunning;
          end else begin
            res_d.task_state = ptdt_pkg::TaskMissing;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctrl_i.proc_step && pend_q[idx] && !susp_q[idx]) begin
      res_d              = '0;
      res_d.result_kind  = ptdt_pkg::KindDispatch;
      res_d.task_key_out = key_q[idx];
      res_d.slot_out     = idx;
      res_d.dispatched   = 1'b1;
      res_d.last         = !later;
      res_valid_d        = 1'b1;
    end
    if (ctrl_i.proc_end && !sent_q) begin
      res_d       = '0;
      res_d.last  = 1'b1;
      res_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      sent_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (ctrl_i.idx_clr) begin
        idx_q  <= '0;
        sent_q <= 1'b0;
      end else if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.exec && cmd_q.opcode == ptdt_pkg::OpAdd &&
          !hit && count_q < ptdt_pkg::CntW'(N)) begin
        count_q <= count_q + 1'b1;
      end
      if (ctrl_i.proc_step && pend_q[idx] && !susp_q[idx]) begin
        sent_q <= 1'b1;
      end
    end
  end

  // Entry store, command latch and result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctrl_i.latch) begin
      cmd_q <= cmd_i;
    end
    if (ctrl_i.exec) begin
      case (cmd_q.opcode)
        ptdt_pkg::OpAdd: begin
          if (hit) begin
            per_q[hit_slot]  <= cmd_q.interval;
          end else if (count_q < ptdt_pkg::CntW'(N)) begin
            key_q[new_slot]  <= cmd_q.task_key;
            per_q[new_slot]  <= cmd_q.interval;
            ctr_q[new_slot]  <= '0;
            pend_q[new_slot] <= 1'b0;
            susp_q[new_slot] <= 1'b0;
          end
        end
        ptdt_pkg::OpSuspend, ptdt_pkg::OpResume: begin
          if (hit) begin
            susp_q[hit_slot] <= (cmd_q.opcode == ptdt_pkg::OpSuspend);
          end
        end
        default: begin
        end
      endcase
    end
    if (ctrl_i.cnt_inc) begin
      ctr_q[idx] <= ctr_next;
    end
    if (ctrl_i.tick_finish && rem_zero) begin
      pend_q[idx] <= 1'b1;
    end
    if (ctrl_i.proc_step && pend_q[idx]) begin
      pend_q[idx] <= 1'b0;
      ctr_q[idx]  <= '0;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

`default_nettype wire

// ===== design/ptdt_ctrl.sv =====
// Controller state machine of the dispatch table; sequences the datapath by
// command and status structs. Depends on ptdt_pkg.
`default_nettype none

module ptdt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [2:0]      op_i,
  input  wire ptdt_pkg::stat_t stat_i,
  output ptdt_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o
);

  ptdt_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptdt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    case (state_q)
      ptdt_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.latch   = 1'b1;
          ctrl_o.idx_clr = 1'b1;
          case (op_i)
            ptdt_pkg::OpTick:    state_d = ptdt_pkg::StTickEntry;
            ptdt_pkg::OpProcess: state_d = ptdt_pkg::StProcScan;
            ptdt_pkg::OpAdd, ptdt_pkg::OpSuspend,
            ptdt_pkg::OpResume, ptdt_pkg::OpQuery: state_d = ptdt_pkg::StExec;
            default:             state_d = ptdt_pkg::StIdle;
          endcase
        end
      end
      ptdt_pkg::StExec: begin
        ctrl_o.exec = 1'b1;
        state_d     = ptdt_pkg::StIdle;
      end
      ptdt_pkg::StTickEntry: begin
        if (stat_i.idx_end) begin
          state_d = ptdt_pkg::StIdle;
        end else begin
          ctrl_o.cnt_inc = 1'b1;
          if (stat_i.tick_eligible) begin
            ctrl_o.rem_start = 1'b1;
            state_d          = ptdt_pkg::StTickWait;
          end else begin
            ctrl_o.idx_inc = 1'b1;
          end
        end
      end
      ptdt_pkg::StTickWait: begin
        if (stat_i.rem_done) begin
          ctrl_o.tick_finish = 1'b1;
          ctrl_o.idx_inc     = 1'b1;
          state_d            = ptdt_pkg::StTickEntry;
        end
      end
      ptdt_pkg::StProcScan: begin
        if (stat_i.idx_end) begin
          ctrl_o.proc_end = 1'b1;
          state_d         = ptdt_pkg::StIdle;
        end else begin
          ctrl_o.proc_step = 1'b1;
          ctrl_o.idx_inc   = 1'b1;
        end
      end
      default: begin
        state_d = ptdt_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/periodic_task_dispatch_table.sv =====
// Top level of the periodic task dispatch table: controller plus datapath.
// Depends on ptdt_pkg, ptdt_ctrl and ptdt_datapath.
//
// Usage: drive cmd_i and raise start; the command transfer happens at the
// clock edge where start is high and busy is low. Opcodes: tick, add,
// suspend, resume, query, process. Results appear on result_o with
// result_valid_o high for exactly one cycle each; the receiver must take
// them then, it cannot stall the block. The last result of a command has
// result_o.last set.
// Add, suspend, resume and query pass through the exec state; add and
// query give one result, registered from that state, and suspend and
// resume give none. Process walks the table at one entry per cycle and
// dispatches at most one pending, running task per cycle.
// Tick visits each entry and gives no result; an entry with a non-zero
// period that is running runs the serial remainder unit, the others do
// not.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module periodic_task_dispatch_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ptdt_pkg::in_t cmd_i,
  output ptdt_pkg::out_t     result_o,
  output logic               result_valid_o
);

  ptdt_pkg::ctrl_t ctrl;
  ptdt_pkg::stat_t stat;

  ptdt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (cmd_i.opcode),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ptdt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire
